### hw/rtl/dlt_pkg.sv
`timescale 1ns / 1ps

package dlt_pkg;

  localparam int MAC_W      = 48;
  localparam int TYPE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 32;
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int PREFIX_W   = 24;
  localparam int OCTET_W    = 8;
  localparam int SECONDS_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_PREFIX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_FIRST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_LAST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEASE_SECONDS  = 3'd3;

  localparam logic [PREFIX_W-1:0]  RST_NETWORK_PREFIX = 24'hC0A801;
  localparam logic [OCTET_W-1:0]   RST_POOL_FIRST     = 8'd100;
  localparam logic [OCTET_W-1:0]   RST_POOL_LAST      = 8'd150;
  localparam logic [SECONDS_W-1:0] RST_LEASE_SECONDS  = 32'd3600;

  localparam logic [TYPE_W-1:0] MSG_DISCOVER = 8'd1;
  localparam logic [TYPE_W-1:0] MSG_REQUEST  = 8'd3;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFFER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] hit_idx;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
  } token_t;

  typedef struct packed {
    logic                 clear;
    logic                 grant_we;
    logic [SLOT_W-1:0]    grant_idx;
    logic                 match_en;
    logic [MAC_W-1:0]     mac;
    logic [SECONDS_W-1:0] now;
    logic [SECONDS_W-1:0] lease;
    logic [COUNT_W-1:0]   usable;
  } cell_ctl_t;

endpackage

### hw/rtl/dlt_req_if.sv
`timescale 1ns / 1ps

interface dlt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [dlt_pkg::MAC_W-1:0]     client_mac;
  logic [dlt_pkg::TYPE_W-1:0]    msg_type;

  modport source (output valid, op, client_mac, msg_type, input ready);
  modport sink (input valid, op, client_mac, msg_type, output ready);
endinterface

### hw/rtl/dlt_rsp_if.sv
`timescale 1ns / 1ps

interface dlt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dlt_pkg::KIND_W-1:0]    reply_kind;
  logic [dlt_pkg::ADDR_W-1:0]    offered_address;
  logic [dlt_pkg::SLOT_W-1:0]    lease_slot;

  modport source (output valid, reply_kind, offered_address, lease_slot, input ready);
  modport sink (input valid, reply_kind, offered_address, lease_slot, output ready);
endinterface

### hw/rtl/dlt_cell.sv
`timescale 1ns / 1ps

module dlt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dlt_pkg::SLOT_W-1:0]  my_idx,
  input  dlt_pkg::cell_ctl_t          ctl,
  input  dlt_pkg::token_t             tok_in,
  output dlt_pkg::token_t             tok_out
);

  logic                             in_use;
  logic [dlt_pkg::MAC_W-1:0]        mac;
  logic [dlt_pkg::SECONDS_W-1:0]    start;
  logic [dlt_pkg::SECONDS_W-1:0]    duration;

  logic                             sweep_here;
  logic                             expired;
  logic                             live;
  logic                             hit;
  logic                             granted;
  logic [dlt_pkg::SECONDS_W-1:0]    age;

  assign sweep_here = tok_in.valid && ({1'b0, my_idx} < ctl.usable);
  assign age        = ctl.now - start;
  assign expired    = in_use && (age >= duration);
  assign live       = in_use && !expired;
  assign hit        = live && ctl.match_en && (mac == ctl.mac);
  assign granted    = ctl.grant_we && (ctl.grant_idx == my_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
    end else if (ctl.clear) begin
      in_use <= 1'b0;
    end else if (granted) begin
      in_use <= 1'b1;
    end else if (sweep_here && expired) begin
      in_use <= 1'b0;
    end

    if (granted) begin
      mac      <= ctl.mac;
      start    <= ctl.now;
      duration <= ctl.lease;
    end else if (sweep_here && hit) begin
      start    <= ctl.now;
      duration <= ctl.lease;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found    <= tok_in.found;
    tok_out.hit_idx  <= tok_in.hit_idx;
    tok_out.free     <= tok_in.free;
    tok_out.free_idx <= tok_in.free_idx;
    if (sweep_here && hit && !tok_in.found) begin
      tok_out.found   <= 1'b1;
      tok_out.hit_idx <= my_idx;
    end
    if (sweep_here && !live && !tok_in.free) begin
      tok_out.free     <= 1'b1;
      tok_out.free_idx <= my_idx;
    end
  end

endmodule

### hw/rtl/dhcp_lease_table.sv
`timescale 1ns / 1ps
// A new request is only taken once the previous one has produced its result beat. The query
// token walks the row of lease cells one cell per cycle, and the lowest free cell is claimed
// after it leaves. A new input beat is taken while the previous result beat still waits.
// Reset clears every lease, the seconds counter and the handshake state.

module dhcp_lease_table #(
  parameter int MAX_LEASES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  dlt_req_if.sink                        req,
  dlt_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [dlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlt_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  localparam logic [dlt_pkg::COUNT_W-1:0] CAP = dlt_pkg::COUNT_W'(MAX_LEASES);

  state_t                            state;
  logic [dlt_pkg::PREFIX_W-1:0]      network_prefix;
  logic [dlt_pkg::OCTET_W-1:0]       pool_first;
  logic [dlt_pkg::OCTET_W-1:0]       pool_last;
  logic [dlt_pkg::SECONDS_W-1:0]     lease_seconds;
  logic [dlt_pkg::SECONDS_W-1:0]     seconds_now;

  logic                              cur_op;
  logic [dlt_pkg::MAC_W-1:0]         cur_mac;
  logic [dlt_pkg::TYPE_W-1:0]        cur_type;
  logic                              launch;
  dlt_pkg::token_t                   fin;

  logic                              rsp_valid;
  logic [dlt_pkg::KIND_W-1:0]        rsp_kind;
  logic [dlt_pkg::ADDR_W-1:0]        rsp_addr;
  logic [dlt_pkg::SLOT_W-1:0]        rsp_slot;

  dlt_pkg::token_t                   tok [MAX_LEASES+1];
  logic [MAX_LEASES-1:0]             tok_valid;
  dlt_pkg::cell_ctl_t                ctl;

  logic [dlt_pkg::COUNT_W-1:0]       span;
  logic [dlt_pkg::COUNT_W-1:0]       usable;
  logic                              grant_msg;
  logic                              finish;
  logic [dlt_pkg::SLOT_W-1:0]        slot_sel;
  logic [dlt_pkg::OCTET_W-1:0]       last_octet;

  assign span   = {1'b0, pool_last} - {1'b0, pool_first} + dlt_pkg::COUNT_W'(1);
  assign usable = (pool_last < pool_first) ? '0 : ((span > CAP) ? CAP : span);

  assign grant_msg = !cur_op && ((cur_type == dlt_pkg::MSG_DISCOVER) ||
                                 (cur_type == dlt_pkg::MSG_REQUEST));
  assign finish    = (state == ST_DONE) && (!rsp_valid || rsp.ready);
  assign slot_sel  = fin.found ? fin.hit_idx : fin.free_idx;
  assign last_octet = pool_first + slot_sel;

  assign ctl.clear     = cfg_we && ((cfg_index == dlt_pkg::REG_POOL_FIRST) ||
                                    (cfg_index == dlt_pkg::REG_POOL_LAST));
  assign ctl.grant_we  = finish && grant_msg && !fin.found && fin.free;
  assign ctl.grant_idx = fin.free_idx;
  assign ctl.match_en  = grant_msg;
  assign ctl.mac       = cur_mac;
  assign ctl.now       = seconds_now;
  assign ctl.lease     = lease_seconds;
  assign ctl.usable    = usable;

  assign tok[0].valid    = launch;
  assign tok[0].found    = 1'b0;
  assign tok[0].hit_idx  = '0;
  assign tok[0].free     = 1'b0;
  assign tok[0].free_idx = '0;

  for (genvar i = 0; i < MAX_LEASES; i++) begin : g_cell
    dlt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (dlt_pkg::SLOT_W'(i)),
      .ctl     (ctl),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign tok_valid[i] = tok[i+1].valid;
  end

  assign req.ready           = (state == ST_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.reply_kind      = rsp_kind;
  assign rsp.offered_address = rsp_addr;
  assign rsp.lease_slot      = rsp_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      network_prefix <= dlt_pkg::RST_NETWORK_PREFIX;
      pool_first     <= dlt_pkg::RST_POOL_FIRST;
      pool_last      <= dlt_pkg::RST_POOL_LAST;
      lease_seconds  <= dlt_pkg::RST_LEASE_SECONDS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlt_pkg::REG_NETWORK_PREFIX: network_prefix <= cfg_data[dlt_pkg::PREFIX_W-1:0];
        dlt_pkg::REG_POOL_FIRST:     pool_first     <= cfg_data[dlt_pkg::OCTET_W-1:0];
        dlt_pkg::REG_POOL_LAST:      pool_last      <= cfg_data[dlt_pkg::OCTET_W-1:0];
        dlt_pkg::REG_LEASE_SECONDS:  lease_seconds  <= cfg_data[dlt_pkg::SECONDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      launch      <= 1'b0;
      rsp_valid   <= 1'b0;
      seconds_now <= '0;
    end else begin
      launch <= 1'b0;
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur_op   <= req.op;
            cur_mac  <= req.client_mac;
            cur_type <= req.msg_type;
            launch   <= 1'b1;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tok[MAX_LEASES].valid) begin
            fin   <= tok[MAX_LEASES];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (finish) begin
            rsp_valid <= 1'b1;
            rsp_kind  <= dlt_pkg::KIND_NONE;
            rsp_addr  <= '0;
            rsp_slot  <= '0;
            if (cur_op) begin
              seconds_now <= seconds_now + dlt_pkg::SECONDS_W'(1);
            end else if (grant_msg) begin
              if (fin.found || fin.free) begin
                rsp_kind <= (cur_type == dlt_pkg::MSG_DISCOVER) ?
                            dlt_pkg::KIND_OFFER : dlt_pkg::KIND_ACK;
                rsp_addr <= {network_prefix, last_octet};
                rsp_slot <= slot_sel;
              end else begin
                rsp_kind <= dlt_pkg::KIND_FULL;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_token_transit: assert property (@(posedge clk) disable iff (rst)
    tok[0].valid |-> ##MAX_LEASES tok[MAX_LEASES].valid)
    else $error("query token did not leave the cell row on time");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one query token in the cell row");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("result beat raised outside the completion step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !$past(ctl.grant_we))
    else $error("lease claimed while a sweep was running");

endmodule
